// ===== rtl/cfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfcc_pkg
// shared types, constants and a crc helper for the can frame crc8 checker
// ----------------------------------------------------------------------------
package cfcc_pkg;

    localparam int unsigned FRAME_W         = 64;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned LEN_W           = 4;
    localparam int unsigned COUNT_W         = 32;
    localparam int unsigned ALIVE_W         = 4;
    localparam int unsigned ADDR_W          = 5;
    localparam int unsigned DATA_W          = 64;
    localparam int unsigned MAX_FRAME_BYTES = 8;
    localparam int unsigned MIN_FRAME_BYTES = 2;

    localparam logic [BYTE_W-1:0]  CRC_POLY    = 8'h2F;
    localparam logic [BYTE_W-1:0]  CRC_INIT    = 8'h00;
    localparam logic [BYTE_W-1:0]  HIGH_NIBBLE = 8'hF0;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_MAGIC_LOW  = 2'd0;
    localparam logic [1:0] REG_MAGIC_HIGH = 2'd1;
    localparam logic [1:0] REG_MSG_LENGTH = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] magic_low;
        logic [DATA_W-1:0] magic_high;
        logic [LEN_W-1:0]  msg_length;
    } t_cfg;

    typedef struct packed {
        logic               crc_match;
        logic [BYTE_W-1:0]  crc_computed;
        logic [BYTE_W-1:0]  crc_received;
        logic [ALIVE_W-1:0] alive_count;
    } t_check;

    // byte fed into the crc, followed by nbytes-1 zero bytes (init zero)
    function automatic logic [BYTE_W-1:0] crc8_advance(
        input logic [BYTE_W-1:0] b,
        input int unsigned       nbytes
    );
        logic [BYTE_W-1:0] c;
        c = b;
        for (int unsigned i = 0; i < BYTE_W * nbytes; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/cfcc_regs.sv =====
// ----------------------------------------------------------------------------
// cfcc_regs
// apb register file: magic tables and message length
// ----------------------------------------------------------------------------
module cfcc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfcc_pkg::ADDR_W-1:0]   paddr,
    input  logic [cfcc_pkg::DATA_W-1:0]   pwdata,
    output logic [cfcc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output cfcc_pkg::t_cfg                o_cfg
);

    cfcc_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_low  <= '0;
            r_cfg.magic_high <= '0;
            r_cfg.msg_length <= cfcc_pkg::LEN_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                cfcc_pkg::REG_MAGIC_LOW:  r_cfg.magic_low  <= pwdata;
                cfcc_pkg::REG_MAGIC_HIGH: r_cfg.magic_high <= pwdata;
                cfcc_pkg::REG_MSG_LENGTH: r_cfg.msg_length <= pwdata[cfcc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            cfcc_pkg::REG_MAGIC_LOW:  prdata = r_cfg.magic_low;
            cfcc_pkg::REG_MAGIC_HIGH: prdata = r_cfg.magic_high;
            cfcc_pkg::REG_MSG_LENGTH: prdata = {{(cfcc_pkg::DATA_W-cfcc_pkg::LEN_W){1'b0}},
                                                r_cfg.msg_length};
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/cfcc_crc.sv =====
// ----------------------------------------------------------------------------
// cfcc_crc
// parallel crc8 of one frame, magic xor and compare
// ----------------------------------------------------------------------------
module cfcc_crc #(
    parameter int unsigned MAX_FRAME_BYTES = cfcc_pkg::MAX_FRAME_BYTES
) (
    input  logic [cfcc_pkg::FRAME_W-1:0] i_frame,
    input  cfcc_pkg::t_cfg               i_cfg,
    output cfcc_pkg::t_check             o_check
);

    localparam int unsigned NPAY = MAX_FRAME_BYTES - 1;

    logic [cfcc_pkg::LEN_W-1:0]   len;
    logic [cfcc_pkg::LEN_W-1:0]   shift;
    logic [cfcc_pkg::BYTE_W-1:0]  pay  [NPAY];
    logic [cfcc_pkg::BYTE_W-1:0]  slot [NPAY];
    logic [cfcc_pkg::BYTE_W-1:0]  crc;
    logic [cfcc_pkg::BYTE_W-1:0]  magic;
    logic [cfcc_pkg::DATA_W-1:0]  magic_word;
    logic [cfcc_pkg::ALIVE_W-1:0] alive;
    logic [cfcc_pkg::BYTE_W-1:0]  received;

    // clamp the length into the supported range
    always_comb begin
        if (i_cfg.msg_length < cfcc_pkg::LEN_W'(cfcc_pkg::MIN_FRAME_BYTES)) begin
            len = cfcc_pkg::LEN_W'(cfcc_pkg::MIN_FRAME_BYTES);
        end else if (i_cfg.msg_length > cfcc_pkg::LEN_W'(MAX_FRAME_BYTES)) begin
            len = cfcc_pkg::LEN_W'(MAX_FRAME_BYTES);
        end else begin
            len = i_cfg.msg_length;
        end
    end

    assign shift = cfcc_pkg::LEN_W'(MAX_FRAME_BYTES) - len;

    // payload bytes, alive nibble masked out of byte 1
    always_comb begin
        for (int m = 0; m < NPAY; m++) begin
            pay[m] = i_frame[cfcc_pkg::BYTE_W*(m+1) +: cfcc_pkg::BYTE_W];
        end
        pay[0] = pay[0] & cfcc_pkg::HIGH_NIBBLE;
    end

    // right-align the used bytes; leading zero bytes leave a zero-init crc alone
    always_comb begin
        for (int m = 0; m < NPAY; m++) begin
            slot[m] = '0;
            for (int k = 0; k < NPAY; k++) begin
                if ((cfcc_pkg::LEN_W'(k) + shift) == cfcc_pkg::LEN_W'(m)) begin
                    slot[m] = pay[k];
                end
            end
        end
    end

    // each slot has a fixed distance to the end, including the trailing zero byte
    always_comb begin
        crc = cfcc_pkg::CRC_INIT;
        for (int m = 0; m < NPAY; m++) begin
            crc = crc ^ cfcc_pkg::crc8_advance(slot[m], MAX_FRAME_BYTES - m);
        end
    end

    assign received   = i_frame[cfcc_pkg::BYTE_W-1:0];
    assign alive      = i_frame[cfcc_pkg::BYTE_W +: cfcc_pkg::ALIVE_W];
    assign magic_word = alive[3] ? i_cfg.magic_high : i_cfg.magic_low;
    assign magic      = magic_word[cfcc_pkg::BYTE_W*alive[2:0] +: cfcc_pkg::BYTE_W];

    assign o_check.crc_computed = crc ^ magic;
    assign o_check.crc_received = received;
    assign o_check.alive_count  = alive;
    assign o_check.crc_match    = ((crc ^ magic) == received);

endmodule

// ===== rtl/can_frame_crc8_checker.sv =====
// ----------------------------------------------------------------------------
// can_frame_crc8_checker
// crc8 and alive counter check of can frames with pass and fail statistics
// ----------------------------------------------------------------------------
// datapath: an accepted frame goes through the input register, then the
//   result register; the crc between them is a single pass of xor logic
// throughput: one frame per cycle while the output is not stalled
// reset: synchronous active low; pipeline empty, counters zero, magic tables
//   zero, message length 8
// ----------------------------------------------------------------------------
module can_frame_crc8_checker #(
    parameter int unsigned MAX_FRAME_BYTES = cfcc_pkg::MAX_FRAME_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cfcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [cfcc_pkg::DATA_W-1:0]    pwdata,
    output logic [cfcc_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    // frame input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [cfcc_pkg::FRAME_W-1:0]   i_frame_data,
    // result output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_crc_match,
    output logic [cfcc_pkg::BYTE_W-1:0]    o_crc_computed,
    output logic [cfcc_pkg::BYTE_W-1:0]    o_crc_received,
    output logic [cfcc_pkg::ALIVE_W-1:0]   o_alive_count,
    output logic [cfcc_pkg::COUNT_W-1:0]   o_pass_total,
    output logic [cfcc_pkg::COUNT_W-1:0]   o_fail_total
);

    cfcc_pkg::t_cfg   cfg;
    cfcc_pkg::t_check check;

    // stage 1: input register
    logic                         r_s1_valid;
    logic [cfcc_pkg::FRAME_W-1:0] r_frame;
    // stage 2: result register
    logic                         r_out_valid;
    cfcc_pkg::t_check             r_check;
    logic [cfcc_pkg::COUNT_W-1:0] r_pass_cnt;
    logic [cfcc_pkg::COUNT_W-1:0] r_fail_cnt;
    logic [cfcc_pkg::COUNT_W-1:0] n_pass_cnt;
    logic [cfcc_pkg::COUNT_W-1:0] n_fail_cnt;

    logic in_beat;
    logic out_free;
    logic s1_move;

    cfcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cfcc_crc #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_crc (
        .i_frame (r_frame),
        .i_cfg   (cfg),
        .o_check (check)
    );

    // result register can take a new beat when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    // input register refills in the same cycle it drains
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_beat    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_beat) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_frame <= i_frame_data;
        end
    end

    // saturating pass and fail counts, bumped as a frame moves into the result
    always_comb begin
        n_pass_cnt = r_pass_cnt;
        n_fail_cnt = r_fail_cnt;
        if (check.crc_match) begin
            if (r_pass_cnt != cfcc_pkg::COUNT_MAX) begin
                n_pass_cnt = r_pass_cnt + 1'b1;
            end
        end else begin
            if (r_fail_cnt != cfcc_pkg::COUNT_MAX) begin
                n_fail_cnt = r_fail_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pass_cnt  <= '0;
            r_fail_cnt  <= '0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
            r_pass_cnt  <= n_pass_cnt;
            r_fail_cnt  <= n_fail_cnt;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_check <= check;
        end
    end

    // counters only move when a new result loads, so they double as the totals
    assign o_out_valid    = r_out_valid;
    assign o_crc_match    = r_check.crc_match;
    assign o_crc_computed = r_check.crc_computed;
    assign o_crc_received = r_check.crc_received;
    assign o_alive_count  = r_check.alive_count;
    assign o_pass_total   = r_pass_cnt;
    assign o_fail_total   = r_fail_cnt;

endmodule

// ===== test/can_frame_crc8_checker_tb.sv =====
// ----------------------------------------------------------------------------
// can_frame_crc8_checker_tb
// self-checking bench for the can frame crc8 checker: a directed table of
// frames and register writes, then random phases with fresh magic tables and
// lengths; every result beat is checked field by field against a predictor
// that tracks the magic tables, the length and the pass and fail counters
// ----------------------------------------------------------------------------
module can_frame_crc8_checker_tb;

    localparam int unsigned NUM_DIRECTED_ROWS = 25;
    localparam int unsigned NUM_PHASES        = 6;
    localparam int unsigned FRAMES_PER_PHASE  = 105;
    localparam int unsigned SETTLE_CYCLES     = 3;
    localparam int unsigned LONG_HOLD_AT      = 150;
    localparam int unsigned LONG_HOLD_CYCLES  = 80;
    localparam int unsigned CYCLE_LIMIT       = 200000;

    typedef enum logic {
        ROW_FRAME,
        ROW_WRITE
    } t_row_kind;

    // one line of the directed table; typed rows carry a hand-derived result
    typedef struct packed {
        t_row_kind                   kind;
        logic [1:0]                  reg_idx;
        logic [cfcc_pkg::DATA_W-1:0] value;
        logic                        typed;
        logic                        exp_match;
        logic [cfcc_pkg::BYTE_W-1:0] exp_crc;
    } t_dir_row;

    // what the sender knows about each frame it offers
    typedef struct packed {
        logic                        typed;
        logic                        exp_match;
        logic [cfcc_pkg::BYTE_W-1:0] exp_crc;
    } t_frame_note;

    typedef struct packed {
        cfcc_pkg::t_check             chk;
        logic [cfcc_pkg::COUNT_W-1:0] pass_total;
        logic [cfcc_pkg::COUNT_W-1:0] fail_total;
    } t_frame_verdict;

    localparam t_dir_row DIRECTED_ROWS [NUM_DIRECTED_ROWS] = '{
        // reset tables: zero payload gives crc zero, so only byte 0 decides
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h0000_0000_0000_0000, 1'b1, 1'b1, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h0000_0000_0000_00FF, 1'b1, 1'b0, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h0000_0000_0000_0F00, 1'b1, 1'b1, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h0000_0000_0000_F000, 1'b0, 1'b0, 8'h00},
        // magic byte k of each table is easy to read back
        '{ROW_WRITE, cfcc_pkg::REG_MAGIC_LOW,  64'h8877_6655_4433_2211, 1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, cfcc_pkg::REG_MAGIC_HIGH, 64'hFFEE_DDCC_BBAA_9900, 1'b0, 1'b0, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h0000_0000_0000_0011, 1'b1, 1'b1, 8'h11},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h0000_0000_0000_0344, 1'b1, 1'b1, 8'h44},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h0000_0000_0000_0C00, 1'b1, 1'b0, 8'hCC},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h0000_0000_0000_0FFF, 1'b1, 1'b1, 8'hFF},
        // length below range acts as two, upper bytes are ignored
        '{ROW_WRITE, cfcc_pkg::REG_MSG_LENGTH, 64'd0,                   1'b0, 1'b0, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'hDEAD_BEEF_CAFE_0011, 1'b1, 1'b1, 8'h11},
        '{ROW_WRITE, cfcc_pkg::REG_MSG_LENGTH, 64'd1,                   1'b0, 1'b0, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'hFFFF_FFFF_FFFF_0700, 1'b1, 1'b0, 8'h88},
        '{ROW_WRITE, cfcc_pkg::REG_MSG_LENGTH, 64'd2,                   1'b0, 1'b0, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h0123_4567_89AB_F5A5, 1'b0, 1'b0, 8'h00},
        // length above range acts as eight
        '{ROW_WRITE, cfcc_pkg::REG_MSG_LENGTH, 64'd15,                  1'b0, 1'b0, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, cfcc_pkg::REG_MSG_LENGTH, 64'd9,                   1'b0, 1'b0, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, cfcc_pkg::REG_MSG_LENGTH, 64'd3,                   1'b0, 1'b0, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'h5555_5555_AAAA_A5F7, 1'b0, 1'b0, 8'h00},
        '{ROW_WRITE, cfcc_pkg::REG_MSG_LENGTH, 64'd8,                   1'b0, 1'b0, 8'h00},
        '{ROW_FRAME, cfcc_pkg::REG_MAGIC_LOW,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h00}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [cfcc_pkg::ADDR_W-1:0]    paddr;
    logic [cfcc_pkg::DATA_W-1:0]    pwdata;
    logic [cfcc_pkg::DATA_W-1:0]    prdata;
    logic                           pready;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [cfcc_pkg::FRAME_W-1:0]   i_frame_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic                           o_crc_match;
    logic [cfcc_pkg::BYTE_W-1:0]    o_crc_computed;
    logic [cfcc_pkg::BYTE_W-1:0]    o_crc_received;
    logic [cfcc_pkg::ALIVE_W-1:0]   o_alive_count;
    logic [cfcc_pkg::COUNT_W-1:0]   o_pass_total;
    logic [cfcc_pkg::COUNT_W-1:0]   o_fail_total;

    // shadow of the register file, updated when a write completes
    cfcc_pkg::t_cfg                 cfg_shadow;
    // predicted counter values
    logic [cfcc_pkg::COUNT_W-1:0]   pass_seen;
    logic [cfcc_pkg::COUNT_W-1:0]   fail_seen;

    t_frame_note                    frame_note_q [$];
    t_frame_verdict                 verdict_q [$];

    int unsigned                    mismatch_count;
    int unsigned                    cycle_count;

    can_frame_crc8_checker u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_frame_data   (i_frame_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_crc_match    (o_crc_match),
        .o_crc_computed (o_crc_computed),
        .o_crc_received (o_crc_received),
        .o_alive_count  (o_alive_count),
        .o_pass_total   (o_pass_total),
        .o_fail_total   (o_fail_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // one byte through the msb-first crc8 shift register
    function automatic logic [cfcc_pkg::BYTE_W-1:0] crc8_shift_byte(
        input logic [cfcc_pkg::BYTE_W-1:0] crc,
        input logic [cfcc_pkg::BYTE_W-1:0] data_byte
    );
        logic [cfcc_pkg::BYTE_W-1:0] acc;
        acc = crc ^ data_byte;
        for (int k = 0; k < cfcc_pkg::BYTE_W; k++) begin
            if (acc[cfcc_pkg::BYTE_W-1]) begin
                acc = {acc[cfcc_pkg::BYTE_W-2:0], 1'b0} ^ cfcc_pkg::CRC_POLY;
            end else begin
                acc = {acc[cfcc_pkg::BYTE_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

    // crc check of one frame under a given register setting
    function automatic cfcc_pkg::t_check predict_check(
        input logic [cfcc_pkg::FRAME_W-1:0] frame,
        input cfcc_pkg::t_cfg               cfg
    );
        int unsigned                 span;
        logic [cfcc_pkg::BYTE_W-1:0] crc;
        logic [cfcc_pkg::BYTE_W-1:0] magic;
        cfcc_pkg::t_check            chk;
        // out-of-range lengths are clamped to the legal window
        span = 32'(cfg.msg_length);
        if (span < cfcc_pkg::MIN_FRAME_BYTES) begin
            span = cfcc_pkg::MIN_FRAME_BYTES;
        end
        if (span > cfcc_pkg::MAX_FRAME_BYTES) begin
            span = cfcc_pkg::MAX_FRAME_BYTES;
        end
        chk.crc_received = frame[cfcc_pkg::BYTE_W-1:0];
        chk.alive_count  = frame[cfcc_pkg::BYTE_W +: cfcc_pkg::ALIVE_W];
        // byte 1 enters with the alive counter nibble masked off
        crc = crc8_shift_byte(cfcc_pkg::CRC_INIT,
                              frame[cfcc_pkg::BYTE_W +: cfcc_pkg::BYTE_W]
                              & cfcc_pkg::HIGH_NIBBLE);
        for (int i = 2; i < cfcc_pkg::MAX_FRAME_BYTES; i++) begin
            if (i < span) begin
                crc = crc8_shift_byte(crc, frame[cfcc_pkg::BYTE_W*i +: cfcc_pkg::BYTE_W]);
            end
        end
        // trailing zero byte
        crc = crc8_shift_byte(crc, 8'h00);
        // counter bit 3 picks the table, bits 2:0 the byte within it
        if (chk.alive_count[3]) begin
            magic = cfg.magic_high[cfcc_pkg::BYTE_W*chk.alive_count[2:0] +: cfcc_pkg::BYTE_W];
        end else begin
            magic = cfg.magic_low[cfcc_pkg::BYTE_W*chk.alive_count[2:0] +: cfcc_pkg::BYTE_W];
        end
        chk.crc_computed = crc ^ magic;
        chk.crc_match    = (chk.crc_computed == chk.crc_received);
        return chk;
    endfunction

    task automatic report_mismatch(
        input string                        field_name,
        input logic [cfcc_pkg::COUNT_W-1:0] got_value,
        input logic [cfcc_pkg::COUNT_W-1:0] want_value
    );
        $display("mismatch %s at cycle %0d: got %0h, expected %0h",
                 field_name, cycle_count, got_value, want_value);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // monitor: checks result beats first, then predicts accepted frames
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : frame_monitor
        t_frame_verdict   got;
        t_frame_verdict   want;
        t_frame_note      note;
        cfcc_pkg::t_check chk;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.chk.crc_match    = o_crc_match;
                got.chk.crc_computed = o_crc_computed;
                got.chk.crc_received = o_crc_received;
                got.chk.alive_count  = o_alive_count;
                got.pass_total       = o_pass_total;
                got.fail_total       = o_fail_total;
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected result beat", '0, '0);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.chk.crc_match !== want.chk.crc_match)
                        report_mismatch("crc_match",
                                        cfcc_pkg::COUNT_W'(got.chk.crc_match),
                                        cfcc_pkg::COUNT_W'(want.chk.crc_match));
                    if (got.chk.crc_computed !== want.chk.crc_computed)
                        report_mismatch("crc_computed",
                                        cfcc_pkg::COUNT_W'(got.chk.crc_computed),
                                        cfcc_pkg::COUNT_W'(want.chk.crc_computed));
                    if (got.chk.crc_received !== want.chk.crc_received)
                        report_mismatch("crc_received",
                                        cfcc_pkg::COUNT_W'(got.chk.crc_received),
                                        cfcc_pkg::COUNT_W'(want.chk.crc_received));
                    if (got.chk.alive_count !== want.chk.alive_count)
                        report_mismatch("alive_count",
                                        cfcc_pkg::COUNT_W'(got.chk.alive_count),
                                        cfcc_pkg::COUNT_W'(want.chk.alive_count));
                    if (got.pass_total !== want.pass_total)
                        report_mismatch("pass_total", got.pass_total, want.pass_total);
                    if (got.fail_total !== want.fail_total)
                        report_mismatch("fail_total", got.fail_total, want.fail_total);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                note = frame_note_q.pop_front();
                chk  = predict_check(i_frame_data, cfg_shadow);
                // directed rows with a hand-derived result override the predictor
                if (note.typed) begin
                    chk.crc_match    = note.exp_match;
                    chk.crc_computed = note.exp_crc;
                end
                // saturating counters
                if (chk.crc_match) begin
                    if (pass_seen != cfcc_pkg::COUNT_MAX) pass_seen = pass_seen + 1'b1;
                end else begin
                    if (fail_seen != cfcc_pkg::COUNT_MAX) fail_seen = fail_seen + 1'b1;
                end
                verdict_q.push_back('{chk, pass_seen, fail_seen});
            end
        end
    end

    // ------------------------------------------------------------------------
    // result sink: random stall per beat, one long hold-off to back up the
    // pipeline while the sender keeps offering
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned long_left;
        int unsigned beats;
        bit          steady;
        hold_left   = 0;
        long_left   = 0;
        beats       = 0;
        steady      = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                beats++;
                // now and then switch between stall-free stretches and jitter
                if ($urandom_range(0, 29) == 0) steady = !steady;
                hold_left = steady ? 0 : $urandom_range(0, 5);
                if (beats == LONG_HOLD_AT) long_left = LONG_HOLD_CYCLES;
            end
            @(negedge i_clk);
            if (long_left > 0) begin
                long_left--;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("can_frame_crc8_checker_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sender side helpers
    // ------------------------------------------------------------------------
    bit sender_steady;

    // offer one frame after a random gap and hold it until accepted
    task automatic send_frame(
        input logic [cfcc_pkg::FRAME_W-1:0] frame,
        input logic                         typed,
        input logic                         exp_match,
        input logic [cfcc_pkg::BYTE_W-1:0]  exp_crc
    );
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
        gap = sender_steady ? 0 : $urandom_range(0, 5);
        frame_note_q.push_back('{typed, exp_match, exp_crc});
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_frame_data <= frame;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_register(input logic [1:0] reg_idx,
                                  input logic [cfcc_pkg::DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            cfcc_pkg::REG_MAGIC_LOW:  cfg_shadow.magic_low  = value;
            cfcc_pkg::REG_MAGIC_HIGH: cfg_shadow.magic_high = value;
            cfcc_pkg::REG_MSG_LENGTH: cfg_shadow.msg_length = value[cfcc_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [cfcc_pkg::FRAME_W-1:0] frame;
        logic [cfcc_pkg::DATA_W-1:0]  magic_lo;
        logic [cfcc_pkg::DATA_W-1:0]  magic_hi;
        logic [cfcc_pkg::LEN_W-1:0]   span;
        logic [5:0]                   flip_bit;
        cfcc_pkg::t_check             chk;
        int unsigned                  pick;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_frame_data   = '0;
        sender_steady  = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        pass_seen      = '0;
        fail_seen      = '0;
        cfg_shadow.magic_low  = '0;
        cfg_shadow.magic_high = '0;
        cfg_shadow.msg_length = cfcc_pkg::LEN_RESET;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; writes only once the block has gone quiet
        for (int r = 0; r < NUM_DIRECTED_ROWS; r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
                drain_results();
                write_register(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].value);
            end else begin
                send_frame(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed,
                           DIRECTED_ROWS[r].exp_match, DIRECTED_ROWS[r].exp_crc);
            end
        end

        // random phases, each with its own tables and length
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    magic_lo = '1;
                    magic_hi = '1;
                    span     = 4'd8;
                end
                1: begin
                    magic_lo = '0;
                    magic_hi = '0;
                    span     = 4'd2;
                end
                2: begin
                    magic_lo = {$urandom, $urandom};
                    magic_hi = {$urandom, $urandom};
                    span     = 4'd0;
                end
                3: begin
                    magic_lo = {$urandom, $urandom};
                    magic_hi = {$urandom, $urandom};
                    span     = 4'd15;
                end
                4: begin
                    magic_lo = {$urandom, $urandom};
                    magic_hi = {$urandom, $urandom};
                    span     = 4'($urandom_range(3, 7));
                end
                default: begin
                    magic_lo = {$urandom, $urandom};
                    magic_hi = {$urandom, $urandom};
                    span     = 4'($urandom_range(0, 15));
                end
            endcase
            drain_results();
            write_register(cfcc_pkg::REG_MAGIC_LOW, magic_lo);
            write_register(cfcc_pkg::REG_MAGIC_HIGH, magic_hi);
            write_register(cfcc_pkg::REG_MSG_LENGTH,
                           {{(cfcc_pkg::DATA_W-cfcc_pkg::LEN_W){1'b0}}, span});

            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                frame = {$urandom, $urandom};
                pick  = $urandom_range(0, 9);
                chk   = predict_check(frame, cfg_shadow);
                if (pick < 7) begin
                    // well-formed frame: crc byte matches the content
                    frame[cfcc_pkg::BYTE_W-1:0] = chk.crc_computed;
                end else if (pick == 7) begin
                    // single bit error in the received crc
                    frame[cfcc_pkg::BYTE_W-1:0] = chk.crc_computed;
                    flip_bit = 6'($urandom_range(0, cfcc_pkg::BYTE_W-1));
                    frame[flip_bit] ^= 1'b1;
                end else if (pick == 8) begin
                    // single bit error in the content, may land in unused bytes
                    frame[cfcc_pkg::BYTE_W-1:0] = chk.crc_computed;
                    flip_bit = 6'($urandom_range(cfcc_pkg::BYTE_W, cfcc_pkg::FRAME_W-1));
                    frame[flip_bit] ^= 1'b1;
                end
                // otherwise plain noise
                send_frame(frame, 1'b0, 1'b0, 8'h00);
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("can_frame_crc8_checker_tb OK");
        end else begin
            $display("can_frame_crc8_checker_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cfcc_pkg.sv
rtl/cfcc_regs.sv
rtl/cfcc_crc.sv
rtl/can_frame_crc8_checker.sv
test/can_frame_crc8_checker_tb.sv
